@@ hdl/trms_pkg.sv @@
`timescale 1ns / 1ps

package trms_pkg;

  // machine sizes
  localparam int REG_COUNT = 32;
  localparam int RAM_WORDS = 1024;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int RAM_AW    = $clog2(RAM_WORDS);

  // clearing sweep limits
  localparam logic [RAM_AW-1:0] CLR_REG_LIMIT = RAM_AW'(REG_COUNT);
  localparam logic [RAM_AW-1:0] RAM_LAST      = RAM_AW'(RAM_WORDS - 1);

  // instruction opcodes
  localparam logic [7:0] OP_PRINT = 8'd0;
  localparam logic [7:0] OP_PUT   = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_STORE = 8'd3;
  localparam logic [7:0] OP_LOAD  = 8'd4;
  localparam logic [7:0] OP_MULT  = 8'd5;

  // classified instruction kind
  typedef enum logic [2:0] {
    K_PRINT = 3'd0,
    K_PUT   = 3'd1,
    K_ADD   = 3'd2,
    K_STORE = 3'd3,
    K_LOAD  = 3'd4,
    K_MULT  = 3'd5
  } kind_t;

  // decoded instruction held in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic [7:0] arg_c;
  } item_t;

endpackage

@@ hdl/trms_front.sv @@
`timescale 1ns / 1ps

module trms_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,   // opcode, arg_a, arg_b, arg_c
  input  logic            clearing,
  output logic            q_valid,
  output trms_pkg::item_t q_item,
  input  logic            q_pop
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  trms_pkg::item_t    queue [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QAW:0]       count;
  logic               known;
  trms_pkg::item_t    dec;
  logic               push;
  logic [7:0]         opcode;

  assign opcode = s_tdata[7:0];

  // classify the opcode, unknown ones are dropped here
  always_comb begin
    known     = 1'b1;
    dec.arg_a = s_tdata[15:8];
    dec.arg_b = s_tdata[23:16];
    dec.arg_c = s_tdata[31:24];
    dec.kind  = trms_pkg::K_PRINT;
    case (opcode)
      trms_pkg::OP_PRINT: dec.kind = trms_pkg::K_PRINT;
      trms_pkg::OP_PUT:   dec.kind = trms_pkg::K_PUT;
      trms_pkg::OP_ADD:   dec.kind = trms_pkg::K_ADD;
      trms_pkg::OP_STORE: dec.kind = trms_pkg::K_STORE;
      trms_pkg::OP_LOAD:  dec.kind = trms_pkg::K_LOAD;
      trms_pkg::OP_MULT:  dec.kind = trms_pkg::K_MULT;
      default:            known    = 1'b0;
    endcase
  end

  assign s_tready = !clearing && (count != (QAW+1)'(QDEPTH));
  assign push     = s_tvalid && s_tready && known;
  assign q_valid  = (count != '0);
  assign q_item   = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= dec;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/trms_exec.sv @@
`timescale 1ns / 1ps

module trms_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  trms_pkg::item_t q_item,
  output logic            q_pop,
  output logic            clearing,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata   // printed_value
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_ISSUE = 4'b0010,
    S_EXEC  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [trms_pkg::DATA_W-1:0]    regs [trms_pkg::REG_COUNT];
  logic [trms_pkg::DATA_W-1:0]    ram  [trms_pkg::RAM_WORDS];

  logic [trms_pkg::RAM_AW-1:0]    clr_addr;
  logic [trms_pkg::RAM_AW-1:0]    clr_addr_next;
  trms_pkg::item_t                cur;
  logic [trms_pkg::DATA_W-1:0]    rd0;
  logic [trms_pkg::DATA_W-1:0]    rd1;
  logic [trms_pkg::DATA_W-1:0]    ram_q;
  logic [trms_pkg::DATA_W-1:0]    prod;
  logic [trms_pkg::REG_IDX_W-1:0] rd_addr0;
  logic [trms_pkg::REG_IDX_W-1:0] rd_addr1;

  logic                           rf_we;
  logic [trms_pkg::REG_IDX_W-1:0] rf_waddr;
  logic [trms_pkg::DATA_W-1:0]    rf_wdata;
  logic                           ram_we;
  logic [trms_pkg::RAM_AW-1:0]    ram_waddr;
  logic [trms_pkg::DATA_W-1:0]    ram_wdata;
  logic                           out_free;
  logic                           out_load;

  assign clearing = (state == S_CLEAR);
  assign out_free = !m_tvalid || m_tready;
  assign prod     = rd0 * rd1;

  // register file read addresses, print always reads register 0
  assign rd_addr0 = (q_item.kind == trms_pkg::K_PRINT) ? '0
                                                        : q_item.arg_b[trms_pkg::REG_IDX_W-1:0];
  assign rd_addr1 = (q_item.kind == trms_pkg::K_STORE) ? q_item.arg_a[trms_pkg::REG_IDX_W-1:0]
                                                        : q_item.arg_c[trms_pkg::REG_IDX_W-1:0];

  // sequencer
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    q_pop         = 1'b0;
    rf_we         = 1'b0;
    rf_waddr      = cur.arg_a[trms_pkg::REG_IDX_W-1:0];
    rf_wdata      = '0;
    ram_we        = 1'b0;
    ram_waddr     = rd0[trms_pkg::RAM_AW-1:0];
    ram_wdata     = rd1;
    out_load      = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr < trms_pkg::CLR_REG_LIMIT) begin
          rf_we    = 1'b1;
          rf_waddr = clr_addr[trms_pkg::REG_IDX_W-1:0];
        end
        if (clr_addr == trms_pkg::RAM_LAST) begin
          state_next = S_ISSUE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_ISSUE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_ISSUE;
        case (cur.kind)
          trms_pkg::K_PUT: begin
            rf_we    = 1'b1;
            rf_wdata = {16'd0, cur.arg_b, cur.arg_c};
          end
          trms_pkg::K_ADD: begin
            rf_we    = 1'b1;
            rf_wdata = rd0 + rd1;
          end
          trms_pkg::K_MULT: begin
            rf_we    = 1'b1;
            rf_wdata = prod;
          end
          trms_pkg::K_STORE: begin
            ram_we = 1'b1;
          end
          trms_pkg::K_LOAD: begin
            state_next = S_LOAD;
          end
          trms_pkg::K_PRINT: begin
            if (out_free) begin
              out_load = 1'b1;
            end else begin
              state_next = S_EXEC;
            end
          end
          default: begin
          end
        endcase
      end
      S_LOAD: begin
        rf_we      = 1'b1;
        rf_wdata   = ram_q;
        state_next = S_ISSUE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  // operand fetch on dequeue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
      rd0 <= regs[rd_addr0];
      rd1 <= regs[rd_addr1];
    end
  end

  // register file write port
  always_ff @(posedge clk) begin
    if (rf_we) begin
      regs[rf_waddr] <= rf_wdata;
    end
  end

  // data ram, one write and one registered read
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[ram_waddr] <= ram_wdata;
    end
    ram_q <= ram[rd0[trms_pkg::RAM_AW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rd0;
    end
  end

endmodule

@@ hdl/toy_register_machine_step_top.sv @@
`timescale 1ns / 1ps

// Register machine with 32 registers of 32 bits and a 1024-word data RAM, one
// instruction per input transfer. After reset the block sweeps the RAM and the
// register file to zero, one word per cycle; s_tready stays low until the sweep
// is done. The front decodes each instruction, drops unknown opcodes at once and
// queues the rest in a four-entry queue. The back executes queued instructions
// one at a time: operand read from the register file on dequeue, then execute
// and write back, with an added RAM read step before the write back for load.
// A print whose result cannot leave the output register waits there while the
// front keeps filling the queue.
module toy_register_machine_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // opcode[7:0], arg_a[15:8], arg_b[23:16], arg_c[31:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // printed_value[31:0]
);

  logic            q_valid;
  trms_pkg::item_t q_item;
  logic            q_pop;
  logic            clearing;

  // decode and queue
  trms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // execute
  trms_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // no transfer is taken while memories are being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input ready during clearing sweep");

  // back only dequeues real entries, and never while clearing
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && !clearing))
    else $error("dequeue without a queued instruction");

  // a clearing sweep always follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> clearing)
    else $error("no clearing sweep after reset");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_INSTRS  = 1900;

  // one instruction, packed so that opcode sits in the low byte of tdata
  typedef struct packed {
    logic [7:0] arg_c;
    logic [7:0] arg_b;
    logic [7:0] arg_a;
    logic [7:0] opcode;
  } instr_t;

  // shadow copy of the machine plus the queue of values that print must emit
  class machine_scoreboard;
    logic [trms_pkg::DATA_W-1:0] regs [trms_pkg::REG_COUNT];
    logic [trms_pkg::DATA_W-1:0] ram [trms_pkg::RAM_WORDS];
    logic [trms_pkg::DATA_W-1:0] print_queue [$];
    int mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (ram[i]) ram[i] = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return print_queue.size();
    endfunction

    // apply one accepted instruction to the shadow state
    function void note_instr(instr_t ins);
      int ra;
      int rb;
      int rc;
      logic [trms_pkg::DATA_W-1:0] addr;
      ra = ins.arg_a % trms_pkg::REG_COUNT;
      rb = ins.arg_b % trms_pkg::REG_COUNT;
      rc = ins.arg_c % trms_pkg::REG_COUNT;
      case (ins.opcode)
        trms_pkg::OP_PRINT: print_queue.push_back(regs[0]);
        trms_pkg::OP_PUT:   regs[ra] = {16'd0, ins.arg_b, ins.arg_c};
        trms_pkg::OP_ADD:   regs[ra] = regs[rb] + regs[rc];
        trms_pkg::OP_MULT:  regs[ra] = regs[rb] * regs[rc];
        trms_pkg::OP_STORE: begin
          addr = regs[rb] % trms_pkg::RAM_WORDS;
          ram[addr] = regs[ra];
        end
        trms_pkg::OP_LOAD: begin
          addr = regs[rb] % trms_pkg::RAM_WORDS;
          regs[ra] = ram[addr];
        end
        default: ;
      endcase
    endfunction

    // compare one output transfer with the oldest expected print
    function void check_print(logic [trms_pkg::DATA_W-1:0] actual);
      logic [trms_pkg::DATA_W-1:0] want;
      if (print_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transfer: printed_value=%h", actual);
        return;
      end
      want = print_queue.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("printed_value mismatch: expected %h actual %h", want, actual);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  machine_scoreboard sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_mode = 0;
  int rx_phase_left = 0;
  int rx_count = 0;

  toy_register_machine_step_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // receiver: ready pattern switches between free flow, coin flips, rare ready and an on/off duty pattern
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_phase_left == 0) begin
      rx_mode       <= $urandom_range(0, 3);
      rx_phase_left <= $urandom_range(20, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ((rx_count % 16) < 11);
    endcase
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_print(m_tdata);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic instr_t make_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b,
                                        logic [7:0] c);
    instr_t ins;
    ins.opcode = op;
    ins.arg_a  = a;
    ins.arg_b  = b;
    ins.arg_c  = c;
    return ins;
  endfunction

  // register operand: mostly in range, sometimes with the upper bits set
  function automatic logic [7:0] pick_reg();
    if ($urandom_range(0, 1) == 0)
      return 8'($urandom_range(0, trms_pkg::REG_COUNT - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // destination biased toward register 0 so that prints see fresh values
  function automatic logic [7:0] pick_dest();
    if ($urandom_range(0, 9) < 3)
      return {3'($urandom_range(0, 7)), 5'd0};
    return pick_reg();
  endfunction

  function automatic instr_t random_instr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18)
      return make_instr(trms_pkg::OP_PRINT, 8'($urandom), 8'($urandom), 8'($urandom));
    if (r < 33)
      return make_instr(trms_pkg::OP_PUT, pick_dest(), 8'($urandom), 8'($urandom));
    if (r < 48)
      return make_instr(trms_pkg::OP_ADD, pick_dest(), pick_reg(), pick_reg());
    if (r < 60)
      return make_instr(trms_pkg::OP_MULT, pick_dest(), pick_reg(), pick_reg());
    if (r < 72)
      return make_instr(trms_pkg::OP_STORE, pick_reg(), pick_reg(), 8'($urandom));
    if (r < 86)
      return make_instr(trms_pkg::OP_LOAD, pick_dest(), pick_reg(), 8'($urandom));
    if (r < 93)
      return make_instr(8'($urandom_range(trms_pkg::OP_MULT + 1, 255)), 8'($urandom),
                        8'($urandom), 8'($urandom));
    return instr_t'($urandom);
  endfunction

  // send one instruction; bursts of back-to-back transfers separated by gaps
  task automatic push_instr(input instr_t ins);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tdata  <= ins;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    sb.note_instr(ins);
    burst_left--;
  endtask

  // store a value through an address register, load it back into r0, print it
  task automatic store_load_roundtrip(inout int counted);
    logic [4:0] addr_reg;
    logic [4:0] val_reg;
    addr_reg = 5'($urandom_range(1, trms_pkg::REG_COUNT - 1));
    val_reg  = 5'($urandom_range(1, trms_pkg::REG_COUNT - 1));
    push_instr(make_instr(trms_pkg::OP_PUT, {3'($urandom), addr_reg}, 8'($urandom),
                          8'($urandom)));
    push_instr(make_instr(trms_pkg::OP_MULT, {3'($urandom), val_reg}, pick_reg(),
                          pick_reg()));
    push_instr(make_instr(trms_pkg::OP_STORE, {3'($urandom), val_reg},
                          {3'($urandom), addr_reg}, 8'($urandom)));
    push_instr(make_instr(trms_pkg::OP_LOAD, 8'd0, {3'($urandom), addr_reg},
                          8'($urandom)));
    push_instr(make_instr(trms_pkg::OP_PRINT, 8'($urandom), 8'($urandom), 8'($urandom)));
    counted += 5;
  endtask

  initial begin
    instr_t directed [$];
    instr_t ins;
    int counted;

    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, immediates at the extremes, wrapping arithmetic,
    // index and address wrap, operand overlap, unknown opcodes
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_PUT,   8'h00, 8'hff, 8'hff));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'hff, 8'hff, 8'hff));
    directed.push_back(make_instr(trms_pkg::OP_PUT,   8'h21, 8'h00, 8'h01));
    directed.push_back(make_instr(trms_pkg::OP_PUT,   8'hff, 8'h80, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_MULT,  8'h03, 8'h00, 8'h20));
    directed.push_back(make_instr(trms_pkg::OP_MULT,  8'h04, 8'h03, 8'he3));
    directed.push_back(make_instr(trms_pkg::OP_ADD,   8'h00, 8'he3, 8'h03));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_STORE, 8'h00, 8'h03, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_LOAD,  8'h06, 8'h01, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_ADD,   8'h00, 8'h06, 8'h1f));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(8'h06,              8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(8'hff,              8'hff, 8'hff, 8'hff));
    directed.push_back(make_instr(trms_pkg::OP_LOAD,  8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_ADD,   8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_MULT,  8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_PUT,   8'he0, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_STORE, 8'h1f, 8'hff, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_LOAD,  8'h00, 8'h08, 8'h00));
    directed.push_back(make_instr(trms_pkg::OP_PRINT, 8'h00, 8'h00, 8'h00));
    foreach (directed[i]) push_instr(directed[i]);

    // random: mostly free mix, with store/load roundtrips mixed in
    counted = 0;
    while (counted < RANDOM_INSTRS) begin
      if ($urandom_range(0, 9) == 0) begin
        store_load_roundtrip(counted);
      end else begin
        ins = random_instr();
        push_instr(ins);
        counted++;
      end
    end
    s_tvalid <= 1'b0;

    // drain outstanding prints, then allow the back end to settle
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
